// ===== sv/icrm_pkg.sv =====
// Shared types and constants for the I2C register-access master with CRC-8.
package icrm_pkg;

  localparam logic [7:0]  CRC_POLY        = 8'h07;
  localparam logic [6:0]  DEV_ADDR_RESET  = 7'd8;
  localparam logic [15:0] HALF_PER_RESET  = 16'd255;
  localparam int          PADDR_W         = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_HALF_PERIOD    = 1'b1;

  // Command codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [7:0] read_crc;
    logic       nack_seen;
  } res_t;

  typedef enum logic [18:0] {
    PH_IDLE     = 19'd1 << 0,
    PH_START_A  = 19'd1 << 1,
    PH_START_B  = 19'd1 << 2,
    PH_TX_LO    = 19'd1 << 3,
    PH_TX_HI    = 19'd1 << 4,
    PH_ACK_LO   = 19'd1 << 5,
    PH_ACK_HI   = 19'd1 << 6,
    PH_RX_LO    = 19'd1 << 7,
    PH_RX_HI    = 19'd1 << 8,
    PH_MACK_LO  = 19'd1 << 9,
    PH_MACK_HI  = 19'd1 << 10,
    PH_MNACK_LO = 19'd1 << 11,
    PH_MNACK_HI = 19'd1 << 12,
    PH_RS_A     = 19'd1 << 13,
    PH_RS_B     = 19'd1 << 14,
    PH_RS_C     = 19'd1 << 15,
    PH_STOP_A   = 19'd1 << 16,
    PH_STOP_B   = 19'd1 << 17,
    PH_STOP_C   = 19'd1 << 18
  } phase_t;

endpackage

// ===== sv/icrm_if.sv =====
// Valid/ready channel interfaces for command and result beats.
interface icrm_cmd_if;
  logic          valid;
  logic          ready;
  icrm_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface icrm_res_if;
  logic          valid;
  logic          ready;
  icrm_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/i2c_crc_register_access_master_top.sv =====
// I2C master for one-byte register writes and reads with CRC-8, one tick per beat.
//
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+-------------
//  cmd     | in  | op, reg_addr, write_data, sda_in               | valid/ready
//  res     | out | scl_out, sda_out, busy_res, done_res,          | valid/ready
//          |     | read_data, read_crc, nack_seen                 |
//  apb     | in  | device_address (0x0), half_period (0x4)        | psel/penable
//
// Each cmd beat is one bus tick and yields exactly one res beat. The tick is
// evaluated in the cycle it is accepted and its result lands in the output
// register, so one beat per clock holds unless res.ready stalls that register.
// cmd.ready is high whenever the output register is empty or being drained.
// Reset (rst, synchronous) returns to idle with both lines released high.
// The CRC of a write is folded one byte per clock in the background after
// the start beat, long before the CRC byte is loaded for transmission.
module i2c_crc_register_access_master_top (
  input  logic                          clk,
  input  logic                          rst,
  icrm_cmd_if.sink                      cmd,
  icrm_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [icrm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Configuration registers
  logic [6:0]  device_address;
  logic [15:0] half_period;

  // Sequencer state
  icrm_pkg::phase_t phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [7:0]  crc_reg, crc_reg_next;
  logic [1:0]  crc_pend, crc_pend_next;   // bytes still to fold into crc_reg
  logic [7:0]  lat_reg_addr, lat_reg_addr_next;
  logic [7:0]  lat_data, lat_data_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        is_read, is_read_next;
  logic [2:0]  byte_idx, byte_idx_next;
  logic        nack, nack_next;
  logic [7:0]  rx_data, rx_data_next;
  logic [7:0]  rx_crc, rx_crc_next;

  // Output register
  logic           out_valid;
  icrm_pkg::res_t out_data;

  logic           accept;
  logic           cfg_wr;
  logic [15:0]    hp;
  logic           done;
  logic           entered;
  logic [3:0]     bc_inc;
  logic [2:0]     bi_inc;
  icrm_pkg::res_t res_next;

  function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ icrm_pkg::CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  // Line levels {scl, sda} driven in each phase
  function automatic logic [1:0] levels(input icrm_pkg::phase_t ph, input logic msb);
    logic [1:0] l;
    case (ph)
      icrm_pkg::PH_START_B, icrm_pkg::PH_RS_C,
      icrm_pkg::PH_MACK_HI, icrm_pkg::PH_STOP_B:   l = 2'b10;
      icrm_pkg::PH_TX_LO:                          l = {1'b0, msb};
      icrm_pkg::PH_TX_HI:                          l = {1'b1, msb};
      icrm_pkg::PH_MACK_LO, icrm_pkg::PH_STOP_A:   l = 2'b00;
      icrm_pkg::PH_ACK_LO, icrm_pkg::PH_RX_LO,
      icrm_pkg::PH_MNACK_LO, icrm_pkg::PH_RS_A:    l = 2'b01;
      default:                                     l = 2'b11;
    endcase
    return l;
  endfunction

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      icrm_pkg::REG_DEVICE_ADDRESS: prdata = {25'd0, device_address};
      icrm_pkg::REG_HALF_PERIOD:    prdata = {16'd0, half_period};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cmd.ready = !out_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign hp        = (half_period == 16'd0) ? 16'd1 : half_period;
  assign bc_inc    = bit_count + 4'd1;
  assign bi_inc    = byte_idx + 3'd1;

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_count_next    = bit_count;
    shift_reg_next    = shift_reg;
    crc_reg_next      = crc_reg;
    crc_pend_next     = crc_pend;
    lat_reg_addr_next = lat_reg_addr;
    lat_data_next     = lat_data;
    scl_next          = scl;
    sda_next          = sda;
    is_read_next      = is_read;
    byte_idx_next     = byte_idx;
    nack_next         = nack;
    rx_data_next      = rx_data;
    rx_crc_next       = rx_crc;
    done              = 1'b0;
    entered           = 1'b0;

    // Background CRC fold: register address, then data byte
    case (crc_pend)
      2'd2: begin
        crc_reg_next  = crc_byte(crc_reg, lat_reg_addr);
        crc_pend_next = 2'd1;
      end
      2'd1: begin
        crc_reg_next  = crc_byte(crc_reg, lat_data);
        crc_pend_next = 2'd0;
      end
      default: ;
    endcase

    if (accept) begin
      if (phase != icrm_pkg::PH_IDLE) begin
        tick_count_next = tick_count + 16'd1;
        if (tick_count_next >= hp) begin
          entered         = 1'b1;
          tick_count_next = 16'd0;
          case (phase)
            icrm_pkg::PH_START_A: phase_next = icrm_pkg::PH_START_B;
            icrm_pkg::PH_START_B: begin
              shift_reg_next = {device_address, 1'b0};
              bit_count_next = 4'd0;
              phase_next     = icrm_pkg::PH_TX_LO;
            end
            icrm_pkg::PH_TX_LO: phase_next = icrm_pkg::PH_TX_HI;
            icrm_pkg::PH_TX_HI: begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              if (bc_inc >= 4'd8) begin
                bit_count_next = 4'd0;
                phase_next     = icrm_pkg::PH_ACK_LO;
              end else begin
                bit_count_next = bc_inc;
                phase_next     = icrm_pkg::PH_TX_LO;
              end
            end
            icrm_pkg::PH_ACK_LO: phase_next = icrm_pkg::PH_ACK_HI;
            icrm_pkg::PH_ACK_HI: begin
              byte_idx_next = bi_inc;
              if (bi_inc == 3'd1) begin
                shift_reg_next = lat_reg_addr;
                bit_count_next = 4'd0;
                phase_next     = icrm_pkg::PH_TX_LO;
              end else if (!is_read && bi_inc == 3'd2) begin
                shift_reg_next = lat_data;
                bit_count_next = 4'd0;
                phase_next     = icrm_pkg::PH_TX_LO;
              end else if (!is_read && bi_inc == 3'd3) begin
                shift_reg_next = crc_reg;
                bit_count_next = 4'd0;
                phase_next     = icrm_pkg::PH_TX_LO;
              end else if (is_read && bi_inc == 3'd2) begin
                phase_next = icrm_pkg::PH_RS_A;
              end else if (is_read && bi_inc == 3'd3) begin
                shift_reg_next = 8'd0;
                bit_count_next = 4'd0;
                phase_next     = icrm_pkg::PH_RX_LO;
              end else begin
                phase_next = icrm_pkg::PH_STOP_A;
              end
            end
            icrm_pkg::PH_RS_A: phase_next = icrm_pkg::PH_RS_B;
            icrm_pkg::PH_RS_B: phase_next = icrm_pkg::PH_RS_C;
            icrm_pkg::PH_RS_C: begin
              shift_reg_next = {device_address, 1'b1};
              bit_count_next = 4'd0;
              phase_next     = icrm_pkg::PH_TX_LO;
            end
            icrm_pkg::PH_RX_LO: phase_next = icrm_pkg::PH_RX_HI;
            icrm_pkg::PH_RX_HI: begin
              if (bc_inc >= 4'd8) begin
                bit_count_next = 4'd0;
                if (byte_idx == 3'd3) begin
                  rx_data_next = shift_reg;
                  phase_next   = icrm_pkg::PH_MACK_LO;
                end else begin
                  rx_crc_next = shift_reg;
                  phase_next  = icrm_pkg::PH_MNACK_LO;
                end
              end else begin
                bit_count_next = bc_inc;
                phase_next     = icrm_pkg::PH_RX_LO;
              end
            end
            icrm_pkg::PH_MACK_LO: phase_next = icrm_pkg::PH_MACK_HI;
            icrm_pkg::PH_MACK_HI: begin
              byte_idx_next  = 3'd4;
              shift_reg_next = 8'd0;
              bit_count_next = 4'd0;
              phase_next     = icrm_pkg::PH_RX_LO;
            end
            icrm_pkg::PH_MNACK_LO: phase_next = icrm_pkg::PH_MNACK_HI;
            icrm_pkg::PH_MNACK_HI: phase_next = icrm_pkg::PH_STOP_A;
            icrm_pkg::PH_STOP_A:   phase_next = icrm_pkg::PH_STOP_B;
            icrm_pkg::PH_STOP_B:   phase_next = icrm_pkg::PH_STOP_C;
            icrm_pkg::PH_STOP_C: begin
              phase_next = icrm_pkg::PH_IDLE;
              done       = 1'b1;
            end
            default: phase_next = icrm_pkg::PH_IDLE;
          endcase
        end
      end else if (cmd.data.op == icrm_pkg::OP_WRITE || cmd.data.op == icrm_pkg::OP_READ) begin
        is_read_next      = (cmd.data.op == icrm_pkg::OP_READ);
        lat_reg_addr_next = cmd.data.reg_addr;
        lat_data_next     = cmd.data.write_data;
        if (cmd.data.op == icrm_pkg::OP_READ) begin
          crc_reg_next  = 8'd0;
          crc_pend_next = 2'd0;
        end else begin
          crc_reg_next  = crc_byte(8'd0, {device_address, 1'b0});
          crc_pend_next = 2'd2;
        end
        byte_idx_next   = 3'd0;
        bit_count_next  = 4'd0;
        nack_next       = 1'b0;
        phase_next      = icrm_pkg::PH_START_A;
        tick_count_next = 16'd0;
        entered         = 1'b1;
      end

      if (entered) begin
        {scl_next, sda_next} = levels(phase_next, shift_reg_next[7]);
      end

      // Sample SDA on the last tick of an SCL-high receive or ack phase
      if ({1'b0, tick_count_next} + 17'd1 >= {1'b0, hp}) begin
        if (phase_next == icrm_pkg::PH_ACK_HI && cmd.data.sda_in) begin
          nack_next = 1'b1;
        end
        if (phase_next == icrm_pkg::PH_RX_HI) begin
          shift_reg_next = {shift_reg_next[6:0], cmd.data.sda_in};
        end
      end
    end

    res_next.scl_out   = scl_next;
    res_next.sda_out   = sda_next;
    res_next.busy_res  = (phase_next != icrm_pkg::PH_IDLE);
    res_next.done_res  = done;
    res_next.read_data = rx_data_next;
    res_next.read_crc  = rx_crc_next;
    res_next.nack_seen = nack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= icrm_pkg::DEV_ADDR_RESET;
      half_period    <= icrm_pkg::HALF_PER_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        icrm_pkg::REG_DEVICE_ADDRESS: device_address <= pwdata[6:0];
        icrm_pkg::REG_HALF_PERIOD:    half_period    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= icrm_pkg::PH_IDLE;
      tick_count   <= 16'd0;
      bit_count    <= 4'd0;
      shift_reg    <= 8'd0;
      crc_reg      <= 8'd0;
      crc_pend     <= 2'd0;
      lat_reg_addr <= 8'd0;
      lat_data     <= 8'd0;
      scl          <= 1'b1;
      sda          <= 1'b1;
      is_read      <= 1'b0;
      byte_idx     <= 3'd0;
      nack         <= 1'b0;
      rx_data      <= 8'd0;
      rx_crc       <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_count    <= bit_count_next;
      shift_reg    <= shift_reg_next;
      crc_reg      <= crc_reg_next;
      crc_pend     <= crc_pend_next;
      lat_reg_addr <= lat_reg_addr_next;
      lat_data     <= lat_data_next;
      scl          <= scl_next;
      sda          <= sda_next;
      is_read      <= is_read_next;
      byte_idx     <= byte_idx_next;
      nack         <= nack_next;
      rx_data      <= rx_data_next;
      rx_crc       <= rx_crc_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted tick
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

endmodule
